// ===== rtl/slre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_pkg
// Shared constants, codes and control/status types of the scanline encoder.
// ----------------------------------------------------------------------------
package slre_pkg;

  localparam int MAX_PIXELS_DEF = 65536;
  localparam int WIDTH_W        = 13;
  localparam int LEN_W          = 10;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd256;

  // candidate length caps
  localparam logic [LEN_W-1:0] CAP_PLAIN = 10'd259;
  localparam logic [LEN_W-1:0] CAP_PAIR  = 10'd516;
  localparam logic [LEN_W-1:0] CAP_COPY  = 10'd258;

  // minimum kept lengths
  localparam logic [LEN_W-1:0] MIN_PLAIN = 10'd4;
  localparam logic [LEN_W-1:0] MIN_PAIR  = 10'd6;
  localparam logic [LEN_W-1:0] MIN_COPY  = 10'd3;

  // token tags
  localparam logic [7:0] TAG_PLAIN = 8'hFD;
  localparam logic [7:0] TAG_PAIR  = 8'hFC;
  localparam logic [7:0] TAG_UP1   = 8'hFF;
  localparam logic [7:0] TAG_UP2   = 8'hFE;
  localparam logic [7:0] TAG_ESC   = 8'hF8;
  localparam logic [7:0] LIT_MAX   = 8'hF7;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_PULL = 1'b1;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_PAIR  = 2'd1,
    MODE_UP1   = 2'd2,
    MODE_UP2   = 2'd3
  } mode_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic div_step;
    logic rd_first;
    logic latch_first;
    logic mode_start;
    logic scan_issue;
    logic scan_adv;
    logic scan_end;
    logic pick;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic op_pull;
    logic empty;
    logic div_last;
    logic skip;
    logic cont;
    logic match;
    logic last_mode;
  } sts_t;

endpackage

// ===== rtl/scanline_rle_image_encoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scanline_rle_image_encoder_core
// Scanline run-length encoder over an on-chip palette frame store.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_ready) carry an operation and a pixel. A load
// appends the pixel to the frame store; a pull returns the next token of
// up to four bytes. Each input word yields exactly one output word on
// out_valid/out_ready. image_width is written on cfg_valid/cfg_ready,
// always ready; the user writes it only while the block is idle, which the
// block itself does not enforce. An encoding pull first works out the
// column remainder bit by bit over the position counter, CW bits wide (17
// by default), then scans the four candidate lengths; each pixel compare
// takes an issue step and a compare step on the frame store.
// One word is in flight at a time; a new word is accepted while the last
// result still waits in the output register, and the block stalls only
// before writing a new result over an untaken one.
// Reset empties the image and sets image_width to 256; the store itself
// is not cleared.
// ----------------------------------------------------------------------------
module scanline_rle_image_encoder_core
  import slre_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         token_length,
  output logic [7:0]         token_byte0,
  output logic [7:0]         token_byte1,
  output logic [7:0]         token_byte2,
  output logic [7:0]         token_byte3,
  output logic               finished,
  output logic               load_overflow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [WIDTH_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  slre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  slre_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .operation     (operation),
    .pixel         (pixel),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .token_length  (token_length),
    .token_byte0   (token_byte0),
    .token_byte1   (token_byte1),
    .token_byte2   (token_byte2),
    .token_byte3   (token_byte3),
    .finished      (finished),
    .load_overflow (load_overflow)
  );

endmodule

// ===== rtl/slre_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module slre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== rtl/slre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_ctrl
// Sequencer: walks one word through load, remainder, scans and token pick.
// ----------------------------------------------------------------------------
module slre_ctrl
  import slre_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_EXEC   = 10'b0000000010,
    S_DIV    = 10'b0000000100,
    S_RDV    = 10'b0000001000,
    S_LATV   = 10'b0000010000,
    S_MSTART = 10'b0000100000,
    S_ISSUE  = 10'b0001000000,
    S_CMP    = 10'b0010000000,
    S_PICK   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.op_pull || sts.empty) state_next = S_EMIT;
        else                           state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_RDV;
      end
      S_RDV: begin
        cmd.rd_first = 1'b1;
        state_next   = S_LATV;
      end
      S_LATV: begin
        cmd.latch_first = 1'b1;
        state_next      = S_MSTART;
      end
      S_MSTART: begin
        cmd.mode_start = 1'b1;
        if (!sts.skip)          state_next = S_ISSUE;
        else if (sts.last_mode) state_next = S_PICK;
      end
      S_ISSUE: begin
        if (sts.cont) begin
          cmd.scan_issue = 1'b1;
          state_next     = S_CMP;
        end else begin
          cmd.scan_end = 1'b1;
          state_next   = sts.last_mode ? S_PICK : S_MSTART;
        end
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.scan_adv = 1'b1;
          state_next   = S_ISSUE;
        end else begin
          cmd.scan_end = 1'b1;
          state_next   = sts.last_mode ? S_PICK : S_MSTART;
        end
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/slre_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_dp
// Datapath: frame store, counters, column remainder, candidate scans, token.
// ----------------------------------------------------------------------------
module slre_dp
  import slre_pkg::*;
#(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               operation,
  input  logic [7:0]         pixel,
  input  logic               cfg_valid,
  input  logic [WIDTH_W-1:0] cfg_data,
  output logic [2:0]         token_length,
  output logic [7:0]         token_byte0,
  output logic [7:0]         token_byte1,
  output logic [7:0]         token_byte2,
  output logic [7:0]         token_byte3,
  output logic               finished,
  output logic               load_overflow
);

  localparam int AW = $clog2(MAX_PIXELS);
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam int IW = (CW > 1) ? $clog2(CW) : 1;
  localparam int XW = CW + WIDTH_W + 2;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

  // control state
  logic [WIDTH_W-1:0] image_width;
  logic [CW-1:0]      loaded;
  logic [CW-1:0]      pos;
  logic               started;

  // word registers and scan registers
  logic               op_q;
  logic [7:0]         px_q;
  logic [WIDTH_W-1:0] rem;
  logic [IW-1:0]      idx;
  logic [7:0]         pa, pb;
  mode_t              mode;
  logic [LEN_W-1:0]   k;
  logic [LEN_W-1:0]   len_q [4];

  // pending result
  logic [2:0] res_len;
  logic [7:0] res_b0, res_b1, res_b2, res_b3;
  logic       res_fin, res_ovf;

  // memory ports
  logic          we, re;
  logic [AW-1:0] waddr, raddr0, raddr1;
  logic [7:0]    rdata0, rdata1;

  logic [WIDTH_W-1:0] weff;
  logic [WIDTH_W:0]   weff2;
  logic [WIDTH_W:0]   div_try;
  logic [WIDTH_W-1:0] rem_row;
  logic [LEN_W-1:0]   cap, lim, step, k_init, skip_len;
  logic               skip;
  logic               empty, ignore_ld, clear_ld;
  logic [CW-1:0]      eff_loaded;
  logic [XW-1:0]      pos_x, loaded_x, back_x, last_x;

  assign weff     = (image_width == '0) ? WIDTH_W'(1) : image_width;
  assign weff2    = {weff, 1'b0};
  assign empty    = (pos >= loaded);
  assign pos_x    = XW'(pos);
  assign loaded_x = XW'(loaded);

  // load decisions
  assign ignore_ld  = started && !empty;
  assign clear_ld   = started && empty;
  assign eff_loaded = clear_ld ? '0 : loaded;

  // restoring remainder step
  assign div_try = {rem, pos[idx]};
  assign rem_row = weff - rem;

  // row limit of the current candidate
  always_comb begin
    case (mode)
      MODE_PLAIN: cap = CAP_PLAIN;
      MODE_PAIR:  cap = CAP_PAIR;
      default:    cap = CAP_COPY;
    endcase
    lim  = (rem_row < WIDTH_W'(cap)) ? LEN_W'(rem_row) : cap;
    step = (mode == MODE_PAIR) ? LEN_W'(2) : LEN_W'(1);
    back_x = (mode == MODE_UP2) ? XW'(weff2) : XW'(weff);
    last_x = pos_x + XW'(k) + XW'(step - LEN_W'(1));
  end

  // candidate start: either a first offset or an immediate length
  always_comb begin
    skip     = 1'b0;
    skip_len = '0;
    k_init   = '0;
    case (mode)
      MODE_PLAIN: k_init = LEN_W'(1);
      MODE_PAIR: begin
        k_init = LEN_W'(2);
        if (pos_x + XW'(1) >= loaded_x) begin
          skip = 1'b1;
        end else if (pos_x + XW'(2) == loaded_x) begin
          skip     = 1'b1;
          skip_len = LEN_W'(2);
        end else if (lim < MIN_PAIR) begin
          skip = 1'b1;
        end
      end
      default: begin
        if (pos_x < back_x) skip = 1'b1;
      end
    endcase
  end

  // status to the sequencer
  always_comb begin
    sts.op_pull   = (op_q == OP_PULL);
    sts.empty     = empty;
    sts.div_last  = (idx == '0);
    sts.skip      = skip;
    sts.cont      = (last_x < loaded_x) && ((k + step - LEN_W'(1)) < lim);
    sts.last_mode = (mode == MODE_UP2);
    case (mode)
      MODE_PLAIN: sts.match = (rdata0 == pa);
      MODE_PAIR:  sts.match = (rdata0 == pa) && (rdata1 == pb);
      default:    sts.match = (rdata0 == rdata1);
    endcase
  end

  // memory addressing
  always_comb begin
    we    = cmd.exec && (op_q == OP_LOAD) && !ignore_ld && (eff_loaded < MAX_CNT);
    waddr = AW'(eff_loaded);
    re    = cmd.rd_first || cmd.scan_issue;
    if (cmd.rd_first) begin
      raddr0 = AW'(pos);
      raddr1 = AW'(pos_x + XW'(1));
    end else begin
      raddr0 = AW'(pos_x + XW'(k));
      if (mode == MODE_PAIR) raddr1 = AW'(pos_x + XW'(k) + XW'(1));
      else                   raddr1 = AW'(pos_x + XW'(k) - back_x);
    end
  end

  slre_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (px_q),
    .re     (re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // token selection
  logic [LEN_W-1:0] best;
  logic [2:0]       p_len;
  logic [7:0]       p_b0, p_b1, p_b2, p_b3;
  always_comb begin
    best = '0;
    p_b3 = '0;
    if (len_q[0] >= MIN_PLAIN) begin
      best  = len_q[0];
      p_len = 3'd3;
      p_b0  = TAG_PLAIN;
      p_b1  = 8'(len_q[0] - MIN_PLAIN);
      p_b2  = pa;
    end else begin
      p_len = (pa <= LIT_MAX) ? 3'd1 : 3'd2;
      p_b0  = (pa <= LIT_MAX) ? pa : TAG_ESC;
      p_b1  = (pa <= LIT_MAX) ? 8'd0 : pa;
      p_b2  = '0;
    end
    if (len_q[1] >= MIN_PAIR && len_q[1] > best) begin
      best  = len_q[1];
      p_len = 3'd4;
      p_b0  = TAG_PAIR;
      p_b1  = 8'((len_q[1] - MIN_PAIR) >> 1);
      p_b2  = pa;
      p_b3  = pb;
    end
    if (len_q[2] >= MIN_COPY && len_q[2] > best) begin
      best  = len_q[2];
      p_len = 3'd2;
      p_b0  = TAG_UP1;
      p_b1  = 8'(len_q[2] - MIN_COPY);
      p_b2  = '0;
      p_b3  = '0;
    end
    if (len_q[3] >= MIN_COPY && len_q[3] > best) begin
      best  = len_q[3];
      p_len = 3'd2;
      p_b0  = TAG_UP2;
      p_b1  = 8'(len_q[3] - MIN_COPY);
      p_b2  = '0;
      p_b3  = '0;
    end
    if (best == '0) best = LEN_W'(1);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= WIDTH_RESET;
      loaded      <= '0;
      pos         <= '0;
      started     <= 1'b0;
    end else begin
      if (cfg_valid) image_width <= cfg_data;
      if (cmd.exec) begin
        if (op_q == OP_LOAD) begin
          if (clear_ld) begin
            pos     <= '0;
            started <= 1'b0;
          end
          if (!ignore_ld) begin
            loaded <= (eff_loaded < MAX_CNT) ? eff_loaded + CW'(1) : eff_loaded;
          end
        end else begin
          started <= 1'b1;
        end
      end
      if (cmd.pick) pos <= CW'(pos_x + XW'(best));
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q <= operation;
      px_q <= pixel;
    end
    // word result defaults at execute
    if (cmd.exec) begin
      res_len <= '0;
      res_b0  <= '0;
      res_b1  <= '0;
      res_b2  <= '0;
      res_b3  <= '0;
      res_fin <= (op_q == OP_PULL) && empty;
      res_ovf <= (op_q == OP_LOAD) && !ignore_ld && (eff_loaded >= MAX_CNT);
      rem     <= '0;
      idx     <= IW'(CW - 1);
    end
    if (cmd.div_step) begin
      rem <= (div_try >= (WIDTH_W+1)'(weff)) ? WIDTH_W'(div_try - (WIDTH_W+1)'(weff))
                                             : WIDTH_W'(div_try);
      idx <= idx - IW'(1);
    end
    if (cmd.latch_first) begin
      pa   <= rdata0;
      pb   <= rdata1;
      mode <= MODE_PLAIN;
    end
    if (cmd.mode_start) begin
      if (skip) begin
        len_q[mode] <= skip_len;
        mode        <= mode_t'(mode + 2'd1);
      end else begin
        k <= k_init;
      end
    end
    if (cmd.scan_adv) k <= k + step;
    if (cmd.scan_end) begin
      len_q[mode] <= k;
      mode        <= mode_t'(mode + 2'd1);
    end
    if (cmd.pick) begin
      res_len <= p_len;
      res_b0  <= p_b0;
      res_b1  <= p_b1;
      res_b2  <= p_b2;
      res_b3  <= p_b3;
    end
    // output word
    if (cmd.emit) begin
      token_length  <= res_len;
      token_byte0   <= res_b0;
      token_byte1   <= res_b1;
      token_byte2   <= res_b2;
      token_byte3   <= res_b3;
      finished      <= res_fin;
      load_overflow <= res_ovf;
    end
  end

endmodule

// ===== rtl/slre_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slre_chk
// Port checker for the scanline encoder, bound to the top level.
// ----------------------------------------------------------------------------
module slre_chk (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] token_length,
  input logic       finished,
  input logic       load_overflow
);

  // hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_length))
    else $error("output word changed while stalled");

  // token never exceeds four bytes
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_length <= 3'd4)
    else $error("token length above four");

  // done word carries no token and no overflow
  a_fin: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> token_length == 3'd0 && !load_overflow)
    else $error("finished word carries data");

  // dropped load carries no token
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid && load_overflow |-> token_length == 3'd0)
    else $error("overflow word carries token");

endmodule

bind scanline_rle_image_encoder_core slre_chk u_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .token_length  (token_length),
  .finished      (finished),
  .load_overflow (load_overflow)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scanline RLE encoder. A behavioral encoder in
// the bench predicts each token from the loaded image and checks every output
// word in order. Directed images cover every token form and corner case, and
// random images built from runs, alternating pairs and repeated rows follow.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import slre_pkg::*;

  localparam int STORE_DEPTH = 65536;
  localparam int QUIET_LIMIT = 40000;

  typedef struct {
    logic [2:0] len;
    logic [7:0] b0, b1, b2, b3;
    logic       fin, ovf;
  } token_t;

  logic clk, rst;
  logic in_valid, in_ready, operation, out_valid, out_ready;
  logic [7:0] pixel;
  logic [2:0] token_length;
  logic [7:0] token_byte0, token_byte1, token_byte2, token_byte3;
  logic finished, load_overflow;
  logic cfg_valid, cfg_ready;
  logic [WIDTH_W-1:0] cfg_data;

  scanline_rle_image_encoder_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .operation(operation), .pixel(pixel),
    .out_valid(out_valid), .out_ready(out_ready),
    .token_length(token_length),
    .token_byte0(token_byte0), .token_byte1(token_byte1),
    .token_byte2(token_byte2), .token_byte3(token_byte3),
    .finished(finished), .load_overflow(load_overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // encoder image and position as the bench sees them
  logic [7:0]  img_px [0:STORE_DEPTH-1];
  int unsigned img_count, enc_pos, cur_width;
  bit          enc_active;

  token_t token_q[$];
  int errors, words_sent, send_idle, recv_idle, quiet_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- encoder
  function automatic int unsigned row_room(int unsigned p, int unsigned w,
                                           int unsigned cap);
    int unsigned r;
    r = w - (p % w);
    return (r < cap) ? r : cap;
  endfunction

  function automatic int unsigned plain_len(int unsigned p, int unsigned w);
    int unsigned lim, j;
    lim = row_room(p, w, 259);
    j = p + 1;
    while (j < img_count && img_px[j] == img_px[p]) begin
      if (j - p >= lim) break;
      j++;
    end
    return j - p;
  endfunction

  function automatic int unsigned pair_len(int unsigned p, int unsigned w);
    int unsigned lim, j;
    lim = row_room(p, w, 516);
    if (p + 1 >= img_count) return 0;
    if (p + 2 == img_count) return 2;
    if (lim < 6) return 0;
    j = p + 2;
    while (j + 1 < img_count && img_px[j] == img_px[p] && img_px[j+1] == img_px[p+1]) begin
      if (j - p + 1 >= lim) break;
      j += 2;
    end
    return j - p;
  endfunction

  function automatic int unsigned copy_len(int unsigned p, int unsigned w,
                                           int unsigned back);
    int unsigned lim, j;
    lim = row_room(p, w, 258);
    j = p;
    if (p < back) return 0;
    while (j < img_count && img_px[j] == img_px[j - back]) begin
      if (j - p >= lim) break;
      j++;
    end
    return j - p;
  endfunction

  function automatic token_t encode_word(logic op, logic [7:0] px);
    token_t t;
    int unsigned w, best, lens[4], need[4];
    int pick;
    logic [7:0] v;
    t = '{len: 0, b0: 0, b1: 0, b2: 0, b3: 0, fin: 0, ovf: 0};
    need = '{4, 6, 3, 3};
    w = (cur_width == 0) ? 1 : cur_width;
    if (op == OP_LOAD) begin
      if (enc_active) begin
        if (enc_pos < img_count) return t;
        img_count = 0;
        enc_pos = 0;
        enc_active = 0;
      end
      if (img_count >= STORE_DEPTH) begin
        t.ovf = 1;
        return t;
      end
      img_px[img_count] = px;
      img_count++;
      return t;
    end
    enc_active = 1;
    if (enc_pos >= img_count) begin
      t.fin = 1;
      return t;
    end
    lens[0] = plain_len(enc_pos, w);
    lens[1] = pair_len(enc_pos, w);
    lens[2] = copy_len(enc_pos, w, w);
    lens[3] = copy_len(enc_pos, w, 2 * w);
    best = 0;
    pick = -1;
    for (int k = 0; k < 4; k++)
      if (lens[k] >= need[k] && lens[k] > best) begin
        best = lens[k];
        pick = k;
      end
    v = img_px[enc_pos];
    case (pick)
      0: begin
        t.len = 3; t.b0 = TAG_PLAIN; t.b1 = 8'(best - 4); t.b2 = v;
      end
      1: begin
        t.len = 4; t.b0 = TAG_PAIR; t.b1 = 8'((best - 6) / 2);
        t.b2 = v; t.b3 = img_px[enc_pos + 1];
      end
      2: begin
        t.len = 2; t.b0 = TAG_UP1; t.b1 = 8'(best - 3);
      end
      3: begin
        t.len = 2; t.b0 = TAG_UP2; t.b1 = 8'(best - 3);
      end
      default: begin
        if (v <= LIT_MAX) begin
          t.len = 1; t.b0 = v;
        end else begin
          t.len = 2; t.b0 = TAG_ESC; t.b1 = v;
        end
        best = 1;
      end
    endcase
    enc_pos += best;
    return t;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_word(logic op, logic [7:0] px);
    in_valid  <= 1'b1;
    operation <= op;
    pixel     <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    token_q.push_back(encode_word(op, px));
    words_sent++;
    // idle the sender now and then
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (token_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_width(logic [WIDTH_W-1:0] w);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_width = w;
  endtask

  task automatic pull_to_end();
    while (enc_pos < img_count || !enc_active) send_word(OP_PULL, $urandom);
  endtask

  // drive out_ready and check each output word
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic void check_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    token_t e;
    if (!rst && out_valid && out_ready) begin
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, actual len %0d", $time,
                 token_length);
      end else begin
        e = token_q.pop_front();
        check_field("token_length", e.len, token_length);
        check_field("token_byte0", e.b0, token_byte0);
        check_field("token_byte1", e.b1, token_byte1);
        check_field("token_byte2", e.b2, token_byte2);
        check_field("token_byte3", e.b3, token_byte3);
        check_field("finished", e.fin, finished);
        check_field("load_overflow", e.ovf, load_overflow);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    logic [7:0] rows [32];
    rows = '{8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h08, 8'hF8, 8'hFF,
             8'h01, 8'h02, 8'h01, 8'h02, 8'h01, 8'h02, 8'h00, 8'hF7,
             8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h08, 8'hF8, 8'hFF,
             8'h07, 8'h07, 8'h07, 8'h07, 8'h07, 8'h08, 8'hF8, 8'hFF};
    // pull on an empty image, then load after done
    send_word(OP_PULL, 8'h00);
    write_width(8);
    foreach (rows[i]) send_word(OP_LOAD, rows[i]);
    send_word(OP_PULL, 8'hFF);
    send_word(OP_LOAD, 8'h55);   // ignored while encoding
    // hold off until every result has come back
    wait_drained();
    pull_to_end();
    send_word(OP_PULL, 8'h00);
    // zero width acts as one column
    write_width(0);
    for (int i = 0; i < 6; i++) send_word(OP_LOAD, (i < 4) ? 8'h09 : 8'hFA);
    pull_to_end();
    send_word(OP_PULL, 8'h00);
  endtask

  task automatic build_image(int unsigned n);
    int unsigned w, i, k, seg;
    logic [7:0] a, b;
    w = (cur_width == 0) ? 1 : cur_width;
    i = 0;
    while (i < n) begin
      seg = $urandom_range(1, 12);
      a = $urandom;
      b = $urandom;
      k = $urandom_range(0, 5);
      for (int s = 0; s < seg && i < n; s++, i++) begin
        case (k)
          0: send_word(OP_LOAD, a);
          1: send_word(OP_LOAD, (s % 2) ? b : a);
          2: send_word(OP_LOAD, (img_count >= w) ? img_px[img_count - w] : a);
          3: send_word(OP_LOAD, (img_count >= 2 * w) ? img_px[img_count - 2 * w] : b);
          default: send_word(OP_LOAD, $urandom);
        endcase
      end
    end
  endtask

  task automatic test_random_images(int budget);
    int stop_at, sel;
    stop_at = words_sent + budget;
    while (words_sent < stop_at) begin
      sel = $urandom_range(0, 19);
      if (sel < 15) write_width($urandom_range(1, 12));
      else if (sel == 15) write_width(0);
      else if (sel == 16) write_width(4096);
      else if (sel == 17) write_width(8191);
      else if (sel == 18) write_width($urandom_range(13, 300));
      build_image($urandom_range(4, 60));
      send_word(OP_PULL, $urandom);
      while (enc_pos < img_count) begin
        // stray loads and a width change in mid-image
        if ($urandom_range(99) < 5) send_word(OP_LOAD, $urandom);
        if ($urandom_range(99) < 3) write_width($urandom_range(1, 10));
        send_word(OP_PULL, $urandom);
      end
      send_word(OP_PULL, $urandom);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; operation = 1'b0; pixel = 8'h00;
    cfg_valid = 1'b0; cfg_data = '0;
    errors = 0; words_sent = 0; quiet_cycles = 0;
    send_idle = 30; recv_idle = 75;
    img_count = 0; enc_pos = 0; enc_active = 0; cur_width = WIDTH_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_images(330);
    send_idle = 75; recv_idle = 30;
    test_random_images(330);
    send_idle = 0; recv_idle = 0;
    test_random_images(330);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
